[hw/rtl/polyphase_decimating_fir_core_assert.svh]
// Assertion macros shared by the polyphase decimating FIR RTL.
`ifndef POLYPHASE_DECIMATING_FIR_CORE_ASSERT_SVH
`define POLYPHASE_DECIMATING_FIR_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PDF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pdf_pkg.sv]
// Sizes, derived widths and coefficient table of the polyphase decimating FIR.
package pdf_pkg;

  localparam int NUM_PHASES     = 9;
  localparam int TAPS_PER_PHASE = 5;
  localparam int SAMPLE_BITS    = 16;
  localparam int SUM_BITS       = 40;

  localparam int HIST_DEPTH = TAPS_PER_PHASE - 1;
  localparam int PHASE_BITS = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;
  localparam int TAP_BITS   = $clog2(TAPS_PER_PHASE);

  // Coefficients are positive and below 4096; one extra bit keeps them signed.
  localparam int COEF_BITS = 13;
  localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
  localparam int TREE_BITS = PROD_BITS + TAP_BITS;

  localparam logic [PHASE_BITS-1:0] LAST_PHASE = PHASE_BITS'(NUM_PHASES - 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [TREE_BITS-1:0]   tree_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;

  // Row k, column j: tap k of phase j. The last row weights the newest sample.
  localparam coef_t COEF_TABLE [TAPS_PER_PHASE][NUM_PHASES] = '{
    '{13'sd1883, 13'sd1700, 13'sd1518, 13'sd1338, 13'sd1163,
      13'sd994,  13'sd833,  13'sd680,  13'sd537},
    '{13'sd3244, 13'sd3140, 13'sd3021, 13'sd2887, 13'sd2740,
      13'sd2583, 13'sd2417, 13'sd2243, 13'sd2064},
    '{13'sd3331, 13'sd3400, 13'sd3449, 13'sd3479, 13'sd3489,
      13'sd3479, 13'sd3449, 13'sd3400, 13'sd3331},
    '{13'sd2064, 13'sd2243, 13'sd2417, 13'sd2583, 13'sd2740,
      13'sd2887, 13'sd3021, 13'sd3140, 13'sd3244},
    '{13'sd537,  13'sd680,  13'sd833,  13'sd994,  13'sd1163,
      13'sd1338, 13'sd1518, 13'sd1700, 13'sd1883}
  };

endpackage

[hw/rtl/polyphase_decimating_fir_core.sv]
// Polyphase decimating FIR core: 45 taps, decimation by 9, one sample per cycle unless stalled.
//
// Usage:
//   The input channel (sample, sample_valid, sample_stall) takes one signed
//   sample per item. The output channel (filtered, filtered_valid,
//   filtered_stall) delivers one 40-bit signed result for every nine samples.
//   Each sample belongs to the phase given by a wrapping counter. Its phase
//   keeps four older samples, and the five samples are weighted by that
//   phase's coefficient column and added into a running sum, which is sent
//   out and cleared after the ninth phase.
// Throughput and pipeline:
//   One item is accepted in every cycle while sample_stall is low. For the
//   ninth sample of a frame, the taps are registered at accept, and the five
//   products, their sum and the running sum are computed from the tap
//   register and land in the output register once the block advances.
// Reset:
//   rst clears the phase counter, the running sum, every phase history and all
//   valid flags; the first sample after reset belongs to phase zero.
// Stalls:
//   The output register holds a result while filtered_stall is high. Samples
//   keep flowing until the next finished frame would have to overwrite a
//   waiting result; only then is sample_stall raised.
module polyphase_decimating_fir_core
  import pdf_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  output logic signed [SUM_BITS-1:0]    filtered,
  output logic                          filtered_valid,
  input  logic                          filtered_stall
);

`include "polyphase_decimating_fir_core_assert.svh"

  // Phase counter and per-phase history (oldest sample at index 0).
  logic [PHASE_BITS-1:0] phase;
  sample_t               hist [NUM_PHASES][HIST_DEPTH];

  // Tap register: the five samples of the current item and their phase.
  logic                  a_valid;
  logic                  a_last;
  logic [PHASE_BITS-1:0] a_phase;
  sample_t               a_taps [TAPS_PER_PHASE];

  // Running sum of the frame in progress.
  sum_t partial_sum;

  logic    accept;
  logic    advance;
  sample_t taps_in [TAPS_PER_PHASE];
  prod_t   prod [TAPS_PER_PHASE];
  tree_t   tree_sum;
  sum_t    sum_next;

  // The block only has to wait when a finished frame would overwrite a
  // result that the receiver has not taken yet.
  assign advance      = !(a_valid && a_last && filtered_valid && filtered_stall);
  assign sample_stall = !advance;
  assign accept       = sample_valid && advance;

  always_comb begin
    for (int k = 0; k < HIST_DEPTH; k++) begin
      taps_in[k] = hist[phase][k];
    end
    taps_in[TAPS_PER_PHASE-1] = sample;
  end

  // One product per tap, each with its phase's fixed coefficient.
  always_comb begin
    for (int k = 0; k < TAPS_PER_PHASE; k++) begin
      prod[k] = a_taps[k] * COEF_TABLE[k][a_phase];
    end
  end

  // Sum of the five products, added into the running sum.
  always_comb begin
    tree_sum = '0;
    for (int k = 0; k < TAPS_PER_PHASE; k++) begin
      tree_sum = tree_sum + TREE_BITS'(prod[k]);
    end
    sum_next = partial_sum + SUM_BITS'(tree_sum);
  end

  // Phase counter and history update at accept time; the same phase comes
  // back only NUM_PHASES items later, long after its taps were captured.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      for (int j = 0; j < NUM_PHASES; j++) begin
        for (int k = 0; k < HIST_DEPTH; k++) begin
          hist[j][k] <= '0;
        end
      end
    end else if (accept) begin
      phase <= (phase == LAST_PHASE) ? '0 : phase + 1'b1;
      for (int k = 0; k < HIST_DEPTH; k++) begin
        hist[phase][k] <= taps_in[k+1];
      end
    end
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid        <= 1'b0;
      a_last         <= 1'b0;
      partial_sum    <= '0;
      filtered_valid <= 1'b0;
    end else begin
      if (advance) begin
        a_valid <= sample_valid;
        a_last  <= (phase == LAST_PHASE);
        if (a_valid) begin
          partial_sum <= a_last ? '0 : sum_next;
        end
      end
      if (advance && a_valid && a_last) begin
        filtered_valid <= 1'b1;
      end else if (!filtered_stall) begin
        filtered_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (advance) begin
      a_phase <= phase;
      a_taps  <= taps_in;
      if (a_valid && a_last) begin
        filtered <= sum_next;
      end
    end
  end

  `PDF_ASSERT_NEXT(a_phase_wrap,
    sample_valid && !sample_stall && phase == LAST_PHASE,
    a_valid && a_last && phase == '0,
    "last phase did not wrap the counter")
  `PDF_ASSERT_NEXT(a_sum_cleared,
    advance && a_valid && a_last,
    partial_sum == '0 && filtered_valid,
    "frame end did not clear the sum and present a result")
  `PDF_ASSERT_SAME(a_result_source,
    $rose(filtered_valid),
    $past(a_valid && a_last),
    "result appeared without a finished frame")
  `PDF_ASSERT_NEXT(a_result_held,
    filtered_valid && filtered_stall,
    filtered_valid && $stable(filtered),
    "stalled result changed or vanished")

endmodule
